// ===== hdl/cbconv_pkg.sv =====
package cbconv_pkg;

    // Default store dimensions
    localparam int DEF_MAX_KERNEL = 7;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_MAX_WIDTH  = 256;

    // Stream payload widths
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 1;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // Signed width for window coordinate arithmetic (covers sizes up to 4096)
    localparam int CW = 14;

    // Request kinds carried in s_axis_tuser
    localparam logic [1:0] OP_LOAD_COEF  = 2'd0;
    localparam logic [1:0] OP_LOAD_PIXEL = 2'd1;
    localparam logic [1:0] OP_COMPUTE    = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd2;

    // Register reset values
    localparam logic [2:0] RST_KERNEL_SIZE  = 3'd3;
    localparam logic [8:0] RST_IMAGE_HEIGHT = 9'd256;
    localparam logic [8:0] RST_IMAGE_WIDTH  = 9'd256;

    // Fixed-point result
    localparam int FRAC_BITS = 12;

    // Control from the sequencer to the MAC pipeline
    typedef struct packed {
        logic clr;  // clear accumulator
        logic vld;  // pixel/coefficient pair present
    } t_mac_ctrl;

endpackage

// ===== hdl/cbconv_mac.sv =====
module cbconv_mac
    import cbconv_pkg::*;
#(
    parameter int ACCW = 40
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_mac_ctrl          i_ctrl,
    input  logic signed [15:0] i_pix,
    input  logic signed [15:0] i_coef,
    output logic signed [15:0] o_value,
    output logic               o_sat,
    output logic               o_busy
);

    logic signed [31:0]   r_prod;
    logic                 r_pv;
    logic signed [ACCW-1:0] r_acc;
    logic signed [ACCW-1:0] w_q;

    // Product stage
    always_ff @(posedge i_clk) begin
        r_prod <= i_pix * i_coef;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctrl.vld;
        end
    end

    // Accumulate
    always_ff @(posedge i_clk) begin
        if (i_ctrl.clr) begin
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= r_acc + ACCW'(r_prod);
        end
    end

    // Arithmetic shift floors; then clip to 16 bits
    assign w_q = r_acc >>> FRAC_BITS;

    always_comb begin
        if (w_q > ACCW'(32767)) begin
            o_value = 16'sh7FFF;
            o_sat   = 1'b1;
        end else if (w_q < -ACCW'(32768)) begin
            o_value = 16'sh8000;
            o_sat   = 1'b1;
        end else begin
            o_value = 16'(w_q);
            o_sat   = 1'b0;
        end
    end

    assign o_busy = r_pv;

endmodule

// ===== hdl/clamped_border_conv2d_core.sv =====
// Loads (coefficient or pixel) leave the block idle; a request is accepted every cycle in idle.
// A compute request steps the sequencer through RUN (one image and one kernel memory read per
// tap), DRAIN and DONE (ks = kernel size in use; a zero ks goes straight to DONE). DONE loads
// the output register once it is free; the next request is accepted as the result appears.
// Reset is synchronous, active low: it clears the sequencer and output valid and restores
// the size registers; image and kernel memories are not cleared.
module clamped_border_conv2d_core
    import cbconv_pkg::*;
#(
    parameter int MAX_KERNEL = DEF_MAX_KERNEL,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // pixel_row, pixel_col, kernel_row, kernel_col, load_value, zero pad
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // opcode
    input  logic [S_TUSER_W-1:0]  s_axis_tuser,
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out_row, out_col, out_value
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // saturated
    output logic [M_TUSER_W-1:0]  m_axis_tuser,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IAW  = (MAX_HEIGHT * MAX_WIDTH > 1) ? $clog2(MAX_HEIGHT * MAX_WIDTH) : 1;
    localparam int KAW  = (MAX_KERNEL * MAX_KERNEL > 1) ? $clog2(MAX_KERNEL * MAX_KERNEL) : 1;
    localparam int KW   = $clog2(MAX_KERNEL + 1);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int CLW  = $clog2(MAX_WIDTH);
    localparam int ACCW = 32 + $clog2(MAX_KERNEL * MAX_KERNEL + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_DONE} t_state;

    // Request fields
    logic [7:0]         w_prow;
    logic [7:0]         w_pcol;
    logic [2:0]         w_krow;
    logic [2:0]         w_kcol;
    logic [15:0]        w_val;
    logic [1:0]         w_op;
    logic               w_acc;

    assign w_prow = s_axis_tdata[7:0];
    assign w_pcol = s_axis_tdata[15:8];
    assign w_krow = s_axis_tdata[18:16];
    assign w_kcol = s_axis_tdata[21:19];
    assign w_val  = s_axis_tdata[37:22];
    assign w_op   = s_axis_tuser;
    assign w_acc  = s_axis_tvalid && s_axis_tready;

    // Configuration registers
    logic [2:0] r_cfg_ks;
    logic [8:0] r_cfg_h;
    logic [8:0] r_cfg_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ks <= RST_KERNEL_SIZE;
            r_cfg_h  <= RST_IMAGE_HEIGHT;
            r_cfg_w  <= RST_IMAGE_WIDTH;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KERNEL_SIZE:  r_cfg_ks <= i_cfg_data[2:0];
                CFG_IMAGE_HEIGHT: r_cfg_h  <= i_cfg_data[8:0];
                CFG_IMAGE_WIDTH:  r_cfg_w  <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Effective sizes: above the store acts as the maximum; a zero height or width acts as one
    logic [KW-1:0]        w_ks;
    logic [KW-1:0]        w_half;
    logic signed [CW-1:0] w_hm1;
    logic signed [CW-1:0] w_wm1;

    assign w_ks   = (32'(r_cfg_ks) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(r_cfg_ks);
    assign w_half = w_ks >> 1;
    assign w_hm1  = (r_cfg_h == '0) ? '0 :
                    (32'(r_cfg_h) > MAX_HEIGHT) ? CW'(MAX_HEIGHT - 1) :
                    CW'(r_cfg_h) - CW'(1);
    assign w_wm1  = (r_cfg_w == '0) ? '0 :
                    (32'(r_cfg_w) > MAX_WIDTH) ? CW'(MAX_WIDTH - 1) :
                    CW'(r_cfg_w) - CW'(1);

    // Sequencer state
    t_state             r_state;
    logic [7:0]         r_prow;
    logic [7:0]         r_pcol;
    logic [KW-1:0]      r_ki;
    logic [KW-1:0]      r_kj;
    logic               r_rv;
    logic               r_m_valid;
    logic [M_TDATA_W-1:0] r_m_data;
    logic               r_m_sat;

    // Window coordinates, clamped to the image in use
    logic signed [CW-1:0] w_row_raw;
    logic signed [CW-1:0] w_col_raw;
    logic signed [CW-1:0] w_row_cl;
    logic signed [CW-1:0] w_col_cl;
    logic [RW-1:0]        w_row;
    logic [CLW-1:0]       w_col;

    assign w_row_raw = $signed({{(CW-8){1'b0}}, r_prow}) + $signed({{(CW-KW){1'b0}}, r_ki})
                     - $signed({{(CW-KW){1'b0}}, w_half});
    assign w_col_raw = $signed({{(CW-8){1'b0}}, r_pcol}) + $signed({{(CW-KW){1'b0}}, r_kj})
                     - $signed({{(CW-KW){1'b0}}, w_half});

    always_comb begin
        if (w_row_raw < 0) begin
            w_row_cl = '0;
        end else if (w_row_raw > w_hm1) begin
            w_row_cl = w_hm1;
        end else begin
            w_row_cl = w_row_raw;
        end
        if (w_col_raw < 0) begin
            w_col_cl = '0;
        end else if (w_col_raw > w_wm1) begin
            w_col_cl = w_wm1;
        end else begin
            w_col_cl = w_col_raw;
        end
    end

    assign w_row = RW'(w_row_cl);
    assign w_col = CLW'(w_col_cl);

    // Memory addressing
    logic            w_rd_en;
    logic [IAW-1:0]  w_img_raddr;
    logic [KAW-1:0]  w_ker_raddr;
    logic            w_img_we;
    logic            w_ker_we;
    logic [IAW-1:0]  w_img_waddr;
    logic [KAW-1:0]  w_ker_waddr;

    assign w_rd_en     = (r_state == ST_RUN);
    assign w_img_raddr = IAW'(32'(w_row) * MAX_WIDTH + 32'(w_col));
    assign w_ker_raddr = KAW'(32'(r_ki) * MAX_KERNEL + 32'(r_kj));

    assign w_img_we    = w_acc && (w_op == OP_LOAD_PIXEL)
                       && (32'(w_prow) < MAX_HEIGHT) && (32'(w_pcol) < MAX_WIDTH);
    assign w_ker_we    = w_acc && (w_op == OP_LOAD_COEF)
                       && (32'(w_krow) < MAX_KERNEL) && (32'(w_kcol) < MAX_KERNEL);
    assign w_img_waddr = IAW'(32'(w_prow) * MAX_WIDTH + 32'(w_pcol));
    assign w_ker_waddr = KAW'(32'(w_krow) * MAX_KERNEL + 32'(w_kcol));

    // Image memory
    logic [15:0]        image_mem [MAX_HEIGHT*MAX_WIDTH];
    logic signed [15:0] r_pix;

    always_ff @(posedge i_clk) begin
        if (w_img_we) begin
            image_mem[w_img_waddr] <= w_val;
        end
        if (w_rd_en) begin
            r_pix <= image_mem[w_img_raddr];
        end
    end

    // Kernel memory
    logic [15:0]        kernel_mem [MAX_KERNEL*MAX_KERNEL];
    logic signed [15:0] r_coef;

    always_ff @(posedge i_clk) begin
        if (w_ker_we) begin
            kernel_mem[w_ker_waddr] <= w_val;
        end
        if (w_rd_en) begin
            r_coef <= kernel_mem[w_ker_raddr];
        end
    end

    // Read-data valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= 1'b0;
        end else begin
            r_rv <= w_rd_en;
        end
    end

    // MAC pipeline
    t_mac_ctrl          w_mac_ctrl;
    logic signed [15:0] w_mac_value;
    logic               w_mac_sat;
    logic               w_mac_busy;

    assign w_mac_ctrl.clr = w_acc && (w_op == OP_COMPUTE);
    assign w_mac_ctrl.vld = r_rv;

    cbconv_mac #(
        .ACCW (ACCW)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_mac_ctrl),
        .i_pix   (r_pix),
        .i_coef  (r_coef),
        .o_value (w_mac_value),
        .o_sat   (w_mac_sat),
        .o_busy  (w_mac_busy)
    );

    // Sequencer and output register
    logic w_last_col;
    logic w_out_free;

    assign w_last_col = (r_kj == w_ks - KW'(1));
    assign w_out_free = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ki      <= '0;
            r_kj      <= '0;
            r_m_valid <= 1'b0;
        end else begin
            // a finishing compute refills the register in the same cycle
            if (r_m_valid && m_axis_tready && (r_state != ST_DONE)) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_acc && (w_op == OP_COMPUTE)) begin
                        r_prow  <= w_prow;
                        r_pcol  <= w_pcol;
                        r_ki    <= '0;
                        r_kj    <= '0;
                        r_state <= (w_ks == '0) ? ST_DONE : ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (w_last_col) begin
                        r_kj <= '0;
                        if (r_ki == w_ks - KW'(1)) begin
                            r_state <= ST_DRAIN;
                        end else begin
                            r_ki <= r_ki + KW'(1);
                        end
                    end else begin
                        r_kj <= r_kj + KW'(1);
                    end
                end
                ST_DRAIN: begin
                    // last product still on its way into the accumulator
                    if (!r_rv && !w_mac_busy) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {w_mac_value, r_pcol, r_prow};
                        r_m_sat   <= w_mac_sat;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_sat;

endmodule

// ===== hdl/cbconv_chk.sv =====
module cbconv_chk
    import cbconv_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [S_TUSER_W-1:0]  s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [M_TDATA_W-1:0]  m_axis_tdata,
    input logic [M_TUSER_W-1:0]  m_axis_tuser
);

    // Reset empties the output register
    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // A compute request occupies the block
    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_COMPUTE) |=> !s_axis_tready)
        else $error("request taken during compute");

    // Loads and ignored requests leave the block ready
    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser != OP_COMPUTE) |=> s_axis_tready)
        else $error("block stalled after a load");

    // A new result appears only as a compute finishes, freeing the input
    a_result_at_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready && $past(!s_axis_tready))
        else $error("result without a finishing compute");

endmodule

bind clamped_border_conv2d_core cbconv_chk u_cbconv_chk (.*);
